// ===== design/lpht_pkg.sv =====
// Shared types and constants for the linear-probe hash table.
// No dependencies; imported by every module of the block but the RAM.
`default_nettype none
package lpht_pkg;

    localparam int SLOTS_DEF  = 16;
    localparam int KEY_W      = 31;
    localparam int ENTRY_W    = KEY_W + 1;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 4;
    localparam int MOD_STEPS  = 2;
    localparam int MSTEP_W    = $clog2(MOD_STEPS);

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic mod_step;
        logic probe_step;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic mod_last;
        logic probe_done;
    } t_stat;

endpackage
`default_nettype wire

// ===== design/lpht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lpht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== design/lpht_datapath.sv =====
// Datapath of the hash table: request registers, home-slot modulo unit,
// probe address/count logic, table RAM and result registers.
// Depends on lpht_pkg and lpht_ram.
`default_nettype none
module lpht_datapath
    import lpht_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    input  wire logic                  i_req_type,
    input  wire logic [KEY_W-1:0]      i_key,
    output t_stat                      o_stat,
    output logic                       o_valid,
    output logic [STATUS_W-1:0]        o_status,
    output logic [SLOT_OUT_W-1:0]      o_slot
);

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int QSHIFT  = KEY_W + SLOT_W;
    localparam int MAGIC_W = KEY_W + 1;
    localparam int PROD_W  = KEY_W + MAGIC_W;
    localparam logic [63:0] MAGIC_WIDE =
        ((64'd1 << QSHIFT) + 64'(SLOTS - 1)) / 64'(SLOTS);
    localparam logic [MAGIC_W-1:0] MAGIC    = MAGIC_W'(MAGIC_WIDE);
    localparam logic [SLOT_W-1:0]  LAST_POS = SLOT_W'(SLOTS - 1);
    localparam logic [SLOT_W-1:0]  SLOTS_LO = SLOT_W'(SLOTS);

    logic                 r_req;
    logic [KEY_W-1:0]     r_key;
    logic [MSTEP_W-1:0]   r_mstep;
    logic [SLOT_W-1:0]    r_qlo;
    logic [PROD_W-1:0]    mul_prod;
    logic [SLOT_W-1:0]    qd_lo;
    logic [SLOT_W-1:0]    n_home;
    logic [SLOT_W-1:0]    r_pos;
    logic [SLOT_W-1:0]    n_pos;
    logic [SLOT_W-1:0]    r_chk_pos;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_chk_live;
    logic                 r_chk_last;
    logic                 r_valid;
    logic [STATUS_W-1:0]  r_status;
    logic [SLOT_OUT_W-1:0] r_slot;

    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic                 rd_valid;
    logic [KEY_W-1:0]     rd_key;

    logic                 n_done;
    logic [STATUS_W-1:0]  n_status;
    logic [SLOT_W-1:0]    n_slot;
    logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;

    assign rd_valid = ram_rdata[KEY_W];
    assign rd_key   = ram_rdata[KEY_W-1:0];
    assign n_pos    = (r_pos == LAST_POS) ? '0 : r_pos + 1'b1;

    // home slot: key mod SLOTS by reciprocal multiply, then subtract
    assign mul_prod = PROD_W'(r_key) * PROD_W'(MAGIC);
    assign qd_lo    = r_qlo * SLOTS_LO;
    assign n_home   = r_key[SLOT_W-1:0] - qd_lo;

    always_comb begin
        n_done   = 1'b0;
        n_status = ST_NOTFOUND;
        n_slot   = '0;
        if (r_chk_live) begin
            if (r_req == REQ_INSERT) begin
                if (!rd_valid) begin
                    n_done   = 1'b1;
                    n_status = ST_INSERTED;
                    n_slot   = r_chk_pos;
                end else if (rd_key == r_key) begin
                    n_done   = 1'b1;
                    n_status = ST_PRESENT;
                    n_slot   = r_chk_pos;
                end else if (r_chk_last) begin
                    n_done   = 1'b1;
                    n_status = ST_FULL;
                end
            end else begin
                if (rd_valid && rd_key == r_key) begin
                    n_done   = 1'b1;
                    n_status = ST_FOUND;
                    n_slot   = r_chk_pos;
                end else if (r_chk_last) begin
                    n_done   = 1'b1;
                    n_status = ST_NOTFOUND;
                end
            end
        end
    end

    assign slot_ext = {{SLOT_OUT_W{1'b0}}, n_slot};

    assign ram_we = i_cmd.clr_step
                  | (i_cmd.probe_step & r_chk_live & (r_req == REQ_INSERT) & !rd_valid);
    assign ram_waddr = i_cmd.clr_step ? r_pos : r_chk_pos;
    assign ram_wdata = i_cmd.clr_step ? '0 : {1'b1, r_key};

    lpht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_cnt      <= '0;
            r_mstep    <= '0;
            r_chk_live <= 1'b0;
            r_chk_last <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= i_cmd.probe_step & n_done;
            if (i_cmd.load) begin
                r_pos      <= '0;
                r_cnt      <= '0;
                r_mstep    <= '0;
                r_chk_live <= 1'b0;
                r_chk_last <= 1'b0;
            end else begin
                r_chk_live <= i_cmd.probe_step & !n_done;
                if (i_cmd.clr_step) begin
                    r_pos <= n_pos;
                end
                if (i_cmd.mod_step) begin
                    r_mstep <= r_mstep + 1'b1;
                    if (o_stat.mod_last) begin
                        r_pos <= n_home;
                    end
                end
                if (i_cmd.probe_step) begin
                    r_pos      <= n_pos;
                    if (!n_done) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_chk_last <= (r_cnt == CNT_W'(SLOTS - 1));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req_type;
            r_key <= i_key;
        end else if (i_cmd.mod_step) begin
            r_qlo <= mul_prod[QSHIFT +: SLOT_W];
        end
        if (i_cmd.probe_step) begin
            r_chk_pos <= r_pos;
        end
        if (i_cmd.probe_step & n_done) begin
            r_status <= n_status;
            r_slot   <= slot_ext[SLOT_OUT_W-1:0];
        end
    end

    assign o_stat.clr_last   = (r_pos == LAST_POS);
    assign o_stat.mod_last   = (r_mstep == MSTEP_W'(MOD_STEPS - 1));
    assign o_stat.probe_done = n_done;

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_slot   = r_slot;

    a_valid_after_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_cmd.probe_step))
        else $error("result without a probe");

    a_miss_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL || o_status == ST_NOTFOUND) |-> o_slot == '0)
        else $error("miss result carries a slot");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(SLOTS))
        else $error("probe count past table size");

    a_search_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_req == REQ_SEARCH |-> o_status == ST_FOUND || o_status == ST_NOTFOUND)
        else $error("search gave an insert status");

endmodule
`default_nettype wire

// ===== design/lpht_ctrl.sv =====
// Controller state machine of the hash table: clear pass, modulo, probe.
// Depends on lpht_pkg.
`default_nettype none
module lpht_ctrl
    import lpht_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire logic  i_req_type,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_MOD   = 2'd2;
    localparam logic [1:0] S_PROBE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_req_type == REQ_INSERT) ? S_MOD : S_PROBE;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_last) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                o_cmd.probe_step = 1'b1;
                if (i_stat.probe_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_MOD || r_state == S_PROBE)
        else $error("load did not start work");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one command");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.probe_step && i_stat.probe_done |=> !o_busy)
        else $error("probe end did not free the block");

endmodule
`default_nettype wire

// ===== design/linear_probe_hash_table_unit.sv =====
// Top level of the linear-probe hash table.
// Depends on lpht_pkg, lpht_ctrl and lpht_datapath.
//
// Usage:
//   Request word: i_req_type (0 insert, 1 search) and i_key, taken at a
//   rising edge where start is high and busy is low.
//   Result word: o_status and o_slot, shown for one cycle with o_valid high.
//   The receiver cannot stall; every request yields exactly one result.
// Sequence:
//   Insert: first forms the home slot (key mod SLOTS: multiply by the
//   reciprocal of SLOTS, then subtract), then one table read a cycle from
//   that slot on; the registered read of the deciding slot is checked and
//   the result is registered onto o_valid. Search scans from slot 0 in the
//   same way, with no modulo step.
//   busy falls in the cycle o_valid rises, so the next request may follow.
//   The table RAM read, one slot a cycle, sets the probe rate.
// Reset:
//   i_rst_n (synchronous) starts a clearing pass that writes each slot in
//   turn and empties every slot; busy stays high until it ends.
`default_nettype none
module linear_probe_hash_table_unit
    import lpht_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    input  wire logic                  i_req_type,
    input  wire logic [KEY_W-1:0]      i_key,
    output logic                       busy,
    output logic                       o_valid,
    output logic [STATUS_W-1:0]        o_status,
    output logic [SLOT_OUT_W-1:0]      o_slot
);

    t_cmd  cmd;
    t_stat stat;

    lpht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    lpht_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_req_type (i_req_type),
        .i_key      (i_key),
        .o_stat     (stat),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_slot     (o_slot)
    );

endmodule
`default_nettype wire

// ===== dv/linear_probe_hash_table_unit_test.sv =====
// Self-checking testbench for linear_probe_hash_table_unit: directed and random
// insert/search words, checked against a behavioral copy of the probing table.
// Depends on lpht_pkg and the design sources of the block.
`timescale 1ns / 1ps
`default_nettype none
module linear_probe_hash_table_unit_test
    import lpht_pkg::*;
();

    localparam int SLOTS      = SLOTS_DEF;
    localparam int NUM_WORDS  = 400;
    localparam int DRAIN_CYC  = SLOTS + 12;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_OUT_W-1:0] slot;
    } t_reply;

    class hash_table_tracker;
        logic [KEY_W-1:0] stored_key [SLOTS];
        bit               occupied   [SLOTS];
        t_reply           due_replies[$];
        int               failures;

        function new();
            failures = 0;
            foreach (occupied[i]) begin
                occupied[i]   = 1'b0;
                stored_key[i] = '0;
            end
        endfunction

        function t_reply probe_table(logic req, logic [KEY_W-1:0] key);
            t_reply r;
            int     pos;
            r.slot = '0;
            if (req == REQ_INSERT) begin
                r.status = ST_FULL;
                pos = key % SLOTS;
                for (int n = 0; n < SLOTS; n++) begin
                    if (!occupied[pos]) begin
                        occupied[pos]   = 1'b1;
                        stored_key[pos] = key;
                        r.status = ST_INSERTED;
                        r.slot   = pos[SLOT_OUT_W-1:0];
                        return r;
                    end
                    if (stored_key[pos] == key) begin
                        r.status = ST_PRESENT;
                        r.slot   = pos[SLOT_OUT_W-1:0];
                        return r;
                    end
                    pos = (pos + 1 == SLOTS) ? 0 : pos + 1;
                end
            end else begin
                r.status = ST_NOTFOUND;
                for (int i = 0; i < SLOTS; i++) begin
                    if (occupied[i] && stored_key[i] == key) begin
                        r.status = ST_FOUND;
                        r.slot   = i[SLOT_OUT_W-1:0];
                        return r;
                    end
                end
            end
            return r;
        endfunction

        function void note_request(logic req, logic [KEY_W-1:0] key);
            due_replies.push_back(probe_table(req, key));
        endfunction

        function void check_reply(logic [STATUS_W-1:0] status, logic [SLOT_OUT_W-1:0] slot);
            t_reply want;
            if (due_replies.size() == 0) begin
                $display("%0t: unexpected result status=%0d slot=%0d", $time, status, slot);
                failures++;
                return;
            end
            want = due_replies.pop_front();
            if (status !== want.status) begin
                $display("%0t: status mismatch expected=%0d actual=%0d",
                         $time, want.status, status);
                failures++;
            end
            if (slot !== want.slot) begin
                $display("%0t: slot mismatch expected=%0d actual=%0d",
                         $time, want.slot, slot);
                failures++;
            end
        endfunction

        function int outstanding();
            return due_replies.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  i_req_type;
    logic [KEY_W-1:0]      i_key;
    logic                  busy;
    logic                  o_valid;
    logic [STATUS_W-1:0]   o_status;
    logic [SLOT_OUT_W-1:0] o_slot;

    hash_table_tracker tracker = new();
    logic [KEY_W-1:0]  known_keys[$];
    int                idle_pct;

    linear_probe_hash_table_unit #(.SLOTS(SLOTS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_key      (i_key),
        .busy       (busy),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_slot     (o_slot)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                tracker.check_reply(o_status, o_slot);
            if (start && !busy)
                tracker.note_request(i_req_type, i_key);
        end
    end

    task automatic send_word(input logic req, input logic [KEY_W-1:0] key);
        while ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start      = 1'b1;
        i_req_type = req;
        i_key      = key;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic drain_replies();
        start = 1'b0;
        while (tracker.outstanding() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_directed();
        logic [KEY_W-1:0] key;
        send_word(REQ_SEARCH, '0);
        send_word(REQ_INSERT, '0);
        send_word(REQ_INSERT, '0);
        send_word(REQ_SEARCH, '0);
        send_word(REQ_INSERT, 31'h7FFF_FFFF);
        send_word(REQ_INSERT, 31'h7FFF_FFEF);
        send_word(REQ_SEARCH, 31'h7FFF_FFEF);
        send_word(REQ_INSERT, 31'h0000_0010);
        send_word(REQ_INSERT, 31'h5555_555E);
        known_keys = '{31'h0, 31'h7FFF_FFFF, 31'h7FFF_FFEF, 31'h10, 31'h5555_555E};
        // pile the remaining free slots onto one home slot
        for (int n = 0; n < 11; n++) begin
            key = (KEY_W'($urandom) & 31'h7FFF_FFF0) | 31'h3;
            known_keys.push_back(key);
            send_word(REQ_INSERT, key);
        end
        send_word(REQ_INSERT, 31'h2AAA_AAA9);
        send_word(REQ_INSERT, key);
        send_word(REQ_SEARCH, key);
        send_word(REQ_SEARCH, 31'h2AAA_AAA9);
    endtask

    task automatic send_random_word();
        int               sel;
        int               bitpos;
        logic [KEY_W-1:0] key;
        sel    = $urandom_range(99);
        bitpos = $urandom_range(KEY_W - 1);
        if (sel < 35) begin
            send_word(REQ_SEARCH, known_keys[$urandom_range(known_keys.size() - 1)]);
        end else if (sel < 50) begin
            send_word(REQ_INSERT, known_keys[$urandom_range(known_keys.size() - 1)]);
        end else if (sel < 70) begin
            send_word(REQ_INSERT, KEY_W'($urandom));
        end else if (sel < 85) begin
            send_word(REQ_SEARCH, KEY_W'($urandom));
        end else begin
            case ($urandom_range(3))
                0: key = '0;
                1: key = '1;
                2: key = 31'(1) << bitpos;
                default: key = ~(31'(1) << bitpos);
            endcase
            send_word(1'($urandom_range(1)), key);
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_req_type = REQ_INSERT;
        i_key      = '0;
        idle_pct   = 32;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        drain_replies();

        for (int n = 0; n < NUM_WORDS - 24; n++) begin
            if (n == (NUM_WORDS - 24) / 3)
                idle_pct = 49;
            else if (n == 2 * (NUM_WORDS - 24) / 3)
                idle_pct = 0;
            if (n == (NUM_WORDS - 24) / 2)
                drain_replies();
            send_random_word();
        end

        drain_replies();
        repeat (DRAIN_CYC) @(negedge i_clk);
        if (tracker.failures == 0 && tracker.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/lpht_pkg.sv
design/lpht_ram.sv
design/lpht_datapath.sv
design/lpht_ctrl.sv
design/linear_probe_hash_table_unit.sv
dv/linear_probe_hash_table_unit_test.sv
